FILE: sv/nsp_pkg.sv
package nsp_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int SCALE_W    = 10;
  localparam int CENTRE_W   = 12;
  localparam int PIX_W      = 14;
  localparam int VIEW_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Default fraction bits of the trig / root values
  localparam int FRAC_BITS_DEF = 15;

  // Sine is stored as a quarter wave of a 512-step circle
  localparam int QUARTER = 128;
  localparam int SINE_IDX_W = 9;

  // pi in Q2.30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Register reset values
  localparam logic [SCALE_W-1:0]  SCALE_RST    = 10'd106;
  localparam logic [CENTRE_W-1:0] CENTRE_A_RST = 12'd106;
  localparam logic [CENTRE_W-1:0] CENTRE_B_RST = 12'd318;
  localparam logic [CENTRE_W-1:0] CENTRE_C_RST = 12'd530;
  localparam logic [CENTRE_W-1:0] CENTRE_V_RST = 12'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_CENTRE_A = 3'd1,
    REG_CENTRE_B = 3'd2,
    REG_CENTRE_C = 3'd3,
    REG_CENTRE_V = 3'd4
  } cfg_reg_e;

  typedef enum logic [VIEW_W-1:0] {
    VIEW_YZ = 2'd0,
    VIEW_XY = 2'd1,
    VIEW_ZX = 2'd2
  } view_e;

  // Taylor term divisor (2n)(2n+1), spelled out per step
  function automatic longint unsigned divide_term(longint unsigned term, int n);
    longint unsigned q;
    case (n)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      6:       q = term / 64'd156;
      7:       q = term / 64'd210;
      8:       q = term / 64'd272;
      9:       q = term / 64'd342;
      10:      q = term / 64'd420;
      11:      q = term / 64'd506;
      default: q = term / 64'd600;
    endcase
    return q;
  endfunction

  // Quarter-wave sine entry k, evaluated at elaboration only
  function automatic longint unsigned quarter_sine(int k, int frac_bits);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint unsigned v;
    int              n;
    x    = (PI_Q30 * 64'(k)) >> 8;
    term = x;
    sum  = $signed(x);
    for (n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = divide_term(term, n);
      if ((n % 2) == 1) sum = sum - $signed(term);
      else              sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    v = ($unsigned(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    if (v > (64'd1 << frac_bits)) v = 64'd1 << frac_bits;
    return v;
  endfunction

  // Rounded sqrt(b / 256) with frac_bits fraction bits, elaboration only
  function automatic longint unsigned root_q(int b, int frac_bits);
    longint unsigned v;
    longint unsigned s;
    longint unsigned t;
    int              i;
    v = 64'(b) << (2 * frac_bits - 8);
    s = 64'd0;
    for (i = 31; i >= 0; i--) begin
      t = s | (64'd1 << i);
      if (t * t <= v) s = t;
    end
    if (v - s * s > s) s = s + 64'd1;
    return s;
  endfunction

endpackage

FILE: sv/nsp_tables.sv
module nsp_tables #(
  parameter int FRAC_BITS = nsp_pkg::FRAC_BITS_DEF
) (
  input  logic [nsp_pkg::BYTE_W-1:0]     root_idx_i,
  input  logic [nsp_pkg::SINE_IDX_W-1:0] sine_idx_i,
  output logic [FRAC_BITS:0]             root_o,
  output logic signed [FRAC_BITS+1:0]    sine_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RootDepth = 1 << nsp_pkg::BYTE_W;

  logic [QW-1:0] quarter_tab [0:nsp_pkg::QUARTER];
  logic [QW-1:0] root_tab    [0:RootDepth-1];

  for (genvar k = 0; k <= nsp_pkg::QUARTER; k++) begin : g_sine
    assign quarter_tab[k] = QW'(nsp_pkg::quarter_sine(k, FRAC_BITS));
  end

  for (genvar k = 0; k < RootDepth; k++) begin : g_root
    assign root_tab[k] = QW'(nsp_pkg::root_q(k, FRAC_BITS));
  end

  logic [7:0]    half_idx;
  logic [7:0]    fold_idx;
  logic [QW-1:0] mag;

  // Fold the half wave onto the stored quarter, then apply the sign
  always_comb begin
    half_idx = sine_idx_i[7:0];
    if ({1'b0, half_idx} <= 9'(nsp_pkg::QUARTER)) begin
      fold_idx = half_idx;
    end else begin
      fold_idx = 8'(9'(2 * nsp_pkg::QUARTER) - {1'b0, half_idx});
    end
    mag = quarter_tab[fold_idx];
    if (sine_idx_i[8]) begin
      sine_o = -$signed({1'b0, mag});
    end else begin
      sine_o = $signed({1'b0, mag});
    end
  end

  assign root_o = root_tab[root_idx_i];

endmodule

FILE: sv/nsp_mul.sv
module nsp_mul #(
  parameter int FRAC_BITS = nsp_pkg::FRAC_BITS_DEF,
  parameter int OP_W      = FRAC_BITS + 2
) (
  input  logic signed [OP_W-1:0] a_i,
  input  logic signed [OP_W-1:0] b_i,
  output logic signed [OP_W-1:0] p_o
);

  localparam int ProdW = 2 * OP_W;
  localparam logic signed [ProdW-1:0] Half = ProdW'(1) << (FRAC_BITS - 1);

  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] biased;
  logic signed [ProdW-1:0] shifted;

  // Round to nearest, ties up: floor((a*b + half) / 2^FRAC_BITS)
  always_comb begin
    prod    = ProdW'(a_i) * ProdW'(b_i);
    biased  = prod + Half;
    shifted = biased >>> FRAC_BITS;
  end

  assign p_o = shifted[OP_W-1:0];

endmodule

FILE: sv/noise_sphere_point_plotter.sv
// Warm-up bytes (the first two after reset) are accepted in idle and give no word.
// Every later byte makes 7 passes through the single shared multiply-round unit,
// then gives 3 result words at one per cycle while the output does not stall; no
// new byte is taken before the last word loads. Output stalls stretch the last phase.
// Reset clears the byte count, newer_q, older_q, the sequencer and the output valid
// and loads the register defaults; sine and root tables are constant logic.
module noise_sphere_point_plotter #(
  parameter int FRAC_BITS = nsp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [nsp_pkg::BYTE_W-1:0]         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [nsp_pkg::PIX_W-1:0]   pixel_x_o,
  output logic signed [nsp_pkg::PIX_W-1:0]   pixel_y_o,
  output logic [nsp_pkg::VIEW_W-1:0]         view_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nsp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [nsp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int OpW = (FRAC_BITS + 2 > nsp_pkg::SCALE_W + 1) ?
                       FRAC_BITS + 2 : nsp_pkg::SCALE_W + 1;
  localparam int PixW = nsp_pkg::PIX_W;
  localparam logic [nsp_pkg::SINE_IDX_W-1:0] CosOfs =
    nsp_pkg::SINE_IDX_W'(nsp_pkg::QUARTER);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_T    = 9'b000000010,
    S_X    = 9'b000000100,
    S_Y    = 9'b000001000,
    S_Z    = 9'b000010000,
    S_OY   = 9'b000100000,
    S_OZ   = 9'b001000000,
    S_OX   = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [nsp_pkg::SCALE_W-1:0]  scale_q;
  logic [nsp_pkg::CENTRE_W-1:0] centre_a_q, centre_b_q, centre_c_q, centre_v_q;

  // Byte history
  logic [1:0]                 bytes_seen_q;
  logic [nsp_pkg::BYTE_W-1:0] newer_q, older_q, phi_q;

  // Datapath
  logic [FRAC_BITS:0]          r_q;
  logic signed [FRAC_BITS+1:0] sin_q;
  logic signed [OpW-1:0]       t_q, x_q, y_q, z_q, oy_q, oz_q, ox_q;

  // Output word register
  nsp_pkg::view_e             view_q;
  logic                       out_valid_q;
  logic signed [PixW-1:0]     pixel_x_q, pixel_y_q;
  logic [nsp_pkg::VIEW_W-1:0] view_out_q;
  logic                       last_q;

  logic in_accept;
  logic out_load;

  logic [nsp_pkg::SINE_IDX_W-1:0] sine_idx;
  logic [FRAC_BITS:0]             root_val;
  logic signed [FRAC_BITS+1:0]    sine_val;
  logic signed [OpW-1:0]          mul_a, mul_b, mul_p;

  logic [nsp_pkg::CENTRE_W-1:0] centre_h;
  logic signed [OpW-1:0]        off_h, off_v;
  logic signed [PixW-1:0]       pixel_x_d, pixel_y_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  nsp_tables #(
    .FRAC_BITS (FRAC_BITS)
  ) u_tables (
    .root_idx_i (data_byte_i),
    .sine_idx_i (sine_idx),
    .root_o     (root_val),
    .sine_o     (sine_val)
  );

  nsp_mul #(
    .FRAC_BITS (FRAC_BITS),
    .OP_W      (OpW)
  ) u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // Prefetch the sine operand of the next pass; after the byte shift,
  // older_q holds the middle byte
  always_comb begin
    case (state_q)
      S_T:     sine_idx = {1'b0, older_q} + CosOfs;
      S_X:     sine_idx = {1'b0, older_q};
      S_Y:     sine_idx = {phi_q, 1'b0} + CosOfs;
      default: sine_idx = {older_q, 1'b0};
    endcase
  end

  always_comb begin
    case (state_q)
      S_T: begin
        mul_a = OpW'($signed({1'b0, r_q}));
        mul_b = OpW'(sin_q);
      end
      S_X, S_Y: begin
        mul_a = t_q;
        mul_b = OpW'(sin_q);
      end
      S_Z: begin
        mul_a = OpW'($signed({1'b0, r_q}));
        mul_b = OpW'(sin_q);
      end
      S_OY: begin
        mul_a = OpW'($signed({1'b0, scale_q}));
        mul_b = y_q;
      end
      S_OZ: begin
        mul_a = OpW'($signed({1'b0, scale_q}));
        mul_b = z_q;
      end
      default: begin
        mul_a = OpW'($signed({1'b0, scale_q}));
        mul_b = x_q;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE: state_d = (in_accept && bytes_seen_q == 2'd2) ? S_T : S_IDLE;
      S_T:    state_d = S_X;
      S_X:    state_d = S_Y;
      S_Y:    state_d = S_Z;
      S_Z:    state_d = S_OY;
      S_OY:   state_d = S_OZ;
      S_OZ:   state_d = S_OX;
      S_OX:   state_d = S_EMIT;
      S_EMIT: state_d = (out_load && view_q == nsp_pkg::VIEW_ZX) ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // Compose the current view's word
  always_comb begin
    case (view_q)
      nsp_pkg::VIEW_YZ: begin
        centre_h = centre_a_q;
        off_h    = oy_q;
        off_v    = oz_q;
      end
      nsp_pkg::VIEW_XY: begin
        centre_h = centre_b_q;
        off_h    = ox_q;
        off_v    = oy_q;
      end
      default: begin
        centre_h = centre_c_q;
        off_h    = oz_q;
        off_v    = ox_q;
      end
    endcase
    pixel_x_d = $signed(PixW'(centre_h)) + PixW'(off_h);
    pixel_y_d = $signed(PixW'(centre_v_q)) - PixW'(off_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bytes_seen_q <= 2'd0;
      newer_q      <= '0;
      older_q      <= '0;
      view_q       <= nsp_pkg::VIEW_YZ;
      out_valid_q  <= 1'b0;
      scale_q      <= nsp_pkg::SCALE_RST;
      centre_a_q   <= nsp_pkg::CENTRE_A_RST;
      centre_b_q   <= nsp_pkg::CENTRE_B_RST;
      centre_c_q   <= nsp_pkg::CENTRE_C_RST;
      centre_v_q   <= nsp_pkg::CENTRE_V_RST;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (nsp_pkg::cfg_reg_e'(cfg_index_i))
          nsp_pkg::REG_SCALE:    scale_q    <= cfg_data_i[nsp_pkg::SCALE_W-1:0];
          nsp_pkg::REG_CENTRE_A: centre_a_q <= cfg_data_i[nsp_pkg::CENTRE_W-1:0];
          nsp_pkg::REG_CENTRE_B: centre_b_q <= cfg_data_i[nsp_pkg::CENTRE_W-1:0];
          nsp_pkg::REG_CENTRE_C: centre_c_q <= cfg_data_i[nsp_pkg::CENTRE_W-1:0];
          nsp_pkg::REG_CENTRE_V: centre_v_q <= cfg_data_i[nsp_pkg::CENTRE_W-1:0];
          default: ;
        endcase
      end

      if (in_accept) begin
        older_q <= newer_q;
        newer_q <= data_byte_i;
        if (bytes_seen_q != 2'd2) bytes_seen_q <= bytes_seen_q + 2'd1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        case (view_q)
          nsp_pkg::VIEW_YZ: view_q <= nsp_pkg::VIEW_XY;
          nsp_pkg::VIEW_XY: view_q <= nsp_pkg::VIEW_ZX;
          default:          view_q <= nsp_pkg::VIEW_YZ;
        endcase
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      phi_q <= older_q;
      r_q   <= root_val;
      sin_q <= sine_val;
    end
    case (state_q)
      S_T: begin
        t_q   <= mul_p;
        sin_q <= sine_val;
      end
      S_X: begin
        x_q   <= mul_p;
        sin_q <= sine_val;
      end
      S_Y: begin
        y_q   <= mul_p;
        sin_q <= sine_val;
      end
      S_Z:  z_q  <= mul_p;
      S_OY: oy_q <= mul_p;
      S_OZ: oz_q <= mul_p;
      S_OX: ox_q <= mul_p;
      default: ;
    endcase
    if (out_load) begin
      pixel_x_q  <= pixel_x_d;
      pixel_y_q  <= pixel_y_d;
      view_out_q <= view_q;
      last_q     <= (view_q == nsp_pkg::VIEW_ZX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign view_o      = view_out_q;
  assign last_o      = last_q;

endmodule
